// ===== rtl/utf8dec_pkg.sv =====
`default_nettype none

package utf8dec_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [30:0] code_point;
		logic [2:0]  bytes_used;
		logic        last_in_run;
		logic        text_done;
	} out_word_t;

	// source of the next output word
	typedef enum logic [1:0] {
		SEL_LEAD      = 2'd0,
		SEL_CONT      = 2'd1,
		SEL_TAIL_NEW  = 2'd2,
		SEL_TAIL_HELD = 2'd3
	} out_sel_t;

	typedef struct packed {
		logic       accept;
		logic       out_load;
		out_sel_t   out_sel;
		logic [1:0] cont_idx;
		logic       last;
		logic       done;
	} dp_cmd_t;

	typedef struct packed {
		logic       flush;
		logic       has_tail;
		logic [2:0] stored;
	} dp_status_t;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_MATCH = 8'h80;
	localparam logic [7:0] CONT_BITS  = 8'h3F;

endpackage

`default_nettype wire

// ===== rtl/utf8_to_codepoint_decoder.sv =====
`default_nettype none

// Channel | valid     | stall     | word
// --------+-----------+-----------+-----------------------------------------
// source  | src_valid | src_stall | src_data  (in_byte, end_of_text)
// sink    | dst_valid | dst_stall | dst_data  (code_point, bytes_used,
//         |           |           |            last_in_run, text_done)
//
// A byte that yields at most one word does not stall the source; one byte per
// cycle is sustained while the sink keeps up and each byte yields at most one word.
// A broken or cut-off sequence yields its lead byte, up to 4 buffered continuation
// bytes and, unless it opens a new sequence, the breaking byte: up to 6 words.
// The source stalls while the words after the first drain from the buffer.
// Reset clears any pending sequence and the output register's valid bit.
// A stalled sink holds the output word and stalls the source behind it.

module utf8_to_codepoint_decoder
	import utf8dec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output logic           src_stall,
	input  wire in_word_t  src_data,
	output logic           dst_valid,
	input  wire logic      dst_stall,
	output out_word_t      dst_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	utf8dec_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.end_of_text (src_data.end_of_text),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.status      (status),
		.cmd         (cmd)
	);

	utf8dec_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_data (src_data),
		.cmd      (cmd),
		.status   (status),
		.dst_data (dst_data)
	);

endmodule

`default_nettype wire

// ===== rtl/utf8dec_dp.sv =====
`default_nettype none

module utf8dec_dp
	import utf8dec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire in_word_t   src_data,
	input  wire dp_cmd_t    cmd,
	output dp_status_t      status,
	output out_word_t       dst_data
);

	logic [7:0]  lead_q;
	logic [2:0]  exp_q;
	logic [2:0]  rcv_q;
	logic [30:0] part_q;
	logic [7:0]  cont_q [4];
	logic [30:0] tail_cp_q;
	logic [2:0]  tail_used_q;
	out_word_t   out_q;

	logic [7:0]  b;
	logic        eot;
	logic        pend;
	logic        is_cont;
	logic [2:0]  rcv_inc;
	logic        complete;
	logic        flush;
	logic        store;
	logic        fresh;
	logic        open_seq;
	logic [2:0]  lead_len;
	logic [7:0]  lead_bits;
	logic [30:0] part_next;
	logic [30:0] tail_cp;
	logic [2:0]  tail_used;
	logic [1:0]  wr_idx;

	assign b        = src_data.in_byte;
	assign eot      = src_data.end_of_text;
	assign pend     = (exp_q != 3'd0);
	assign is_cont  = ((b & CONT_MASK) == CONT_MATCH);
	assign rcv_inc  = rcv_q + 3'd1;
	assign complete = pend && is_cont && (rcv_inc >= exp_q);
	assign flush    = pend && (!is_cont || (!complete && eot));
	assign store    = pend && is_cont && !complete && !eot;
	assign fresh    = !pend || !is_cont;
	assign open_seq = fresh && (lead_len != 3'd0) && !eot;
	assign wr_idx   = rcv_inc[1:0] - 2'd2;

	// lead byte class and its payload bits
	always_comb begin
		lead_len  = 3'd0;
		lead_bits = 8'h00;
		if ((b & 8'hE0) == 8'hC0) begin
			lead_len  = 3'd2;
			lead_bits = b & 8'h1F;
		end else if ((b & 8'hF0) == 8'hE0) begin
			lead_len  = 3'd3;
			lead_bits = b & 8'h0F;
		end else if ((b & 8'hF8) == 8'hF0) begin
			lead_len  = 3'd4;
			lead_bits = b & 8'h07;
		end else if ((b & 8'hFC) == 8'hF8) begin
			lead_len  = 3'd5;
			lead_bits = b & 8'h03;
		end else if ((b & 8'hFE) == 8'hFC) begin
			lead_len  = 3'd6;
			lead_bits = b & 8'h01;
		end
	end

	assign part_next = {part_q[24:0], b[5:0] & CONT_BITS[5:0]};

	always_comb begin
		if (complete) begin
			tail_cp   = part_next;
			tail_used = exp_q;
		end else begin
			tail_cp   = {23'd0, b};
			tail_used = 3'd1;
		end
	end

	assign status.flush    = flush;
	assign status.has_tail = complete || (flush && is_cont) || (fresh && !open_seq);
	assign status.stored   = (rcv_q == 3'd0) ? 3'd0 : rcv_q - 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 8'h00;
			exp_q  <= 3'd0;
			rcv_q  <= 3'd0;
			part_q <= 31'd0;
		end else if (cmd.accept) begin
			if (complete || flush) begin
				exp_q  <= 3'd0;
				rcv_q  <= 3'd0;
				part_q <= 31'd0;
			end
			if (store) begin
				rcv_q  <= rcv_inc;
				part_q <= part_next;
			end
			if (open_seq) begin
				lead_q <= b;
				exp_q  <= lead_len;
				rcv_q  <= 3'd1;
				part_q <= {23'd0, lead_bits};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tail_cp_q   <= tail_cp;
			tail_used_q <= tail_used;
			if (store) begin
				cont_q[wr_idx] <= b;
			end
		end
		if (cmd.out_load) begin
			out_q.last_in_run <= cmd.last;
			out_q.text_done   <= cmd.done;
			case (cmd.out_sel)
				SEL_LEAD: begin
					out_q.code_point <= {23'd0, lead_q};
					out_q.bytes_used <= 3'd1;
				end
				SEL_CONT: begin
					out_q.code_point <= {23'd0, cont_q[cmd.cont_idx]};
					out_q.bytes_used <= 3'd1;
				end
				SEL_TAIL_NEW: begin
					out_q.code_point <= tail_cp;
					out_q.bytes_used <= tail_used;
				end
				SEL_TAIL_HELD: begin
					out_q.code_point <= tail_cp_q;
					out_q.bytes_used <= tail_used_q;
				end
				default: begin
					out_q.code_point <= tail_cp_q;
					out_q.bytes_used <= tail_used_q;
				end
			endcase
		end
	end

	assign dst_data = out_q;

endmodule

`default_nettype wire

// ===== rtl/utf8dec_ctrl.sv =====
`default_nettype none

module utf8dec_ctrl
	import utf8dec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic        end_of_text,
	output logic             dst_valid,
	input  wire logic        dst_stall,
	input  wire dp_status_t  status,
	output dp_cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONT,
		ST_TAIL
	} state_t;

	state_t     state_q;
	logic       out_valid_q;
	logic [2:0] stored_q;
	logic [1:0] idx_q;
	logic       has_tail_q;
	logic       eot_q;

	logic       adv;
	logic       accept;
	logic       lead_last;
	logic       cont_end;

	assign adv       = !out_valid_q || !dst_stall;
	assign src_stall = (state_q != ST_IDLE) || !adv;
	assign accept    = src_valid && !src_stall;
	assign dst_valid = out_valid_q;
	assign lead_last = (status.stored == 3'd0) && !status.has_tail;
	assign cont_end  = ({1'b0, idx_q} + 3'd1) == stored_q;

	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.out_sel  = SEL_TAIL_NEW;
		cmd.cont_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && status.flush) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_LEAD;
					cmd.last     = lead_last;
					cmd.done     = lead_last && end_of_text;
				end else if (accept && status.has_tail) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_TAIL_NEW;
					cmd.last     = 1'b1;
					cmd.done     = end_of_text;
				end
			end
			ST_CONT: begin
				cmd.out_load = adv;
				cmd.out_sel  = SEL_CONT;
				cmd.last     = cont_end && !has_tail_q;
				cmd.done     = cont_end && !has_tail_q && eot_q;
			end
			ST_TAIL: begin
				cmd.out_load = adv;
				cmd.out_sel  = SEL_TAIL_HELD;
				cmd.last     = 1'b1;
				cmd.done     = eot_q;
			end
			default: begin
				cmd.out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			stored_q    <= 3'd0;
			idx_q       <= 2'd0;
			has_tail_q  <= 1'b0;
			eot_q       <= 1'b0;
		end else begin
			// drop the word once taken; a load below sets it again
			if (out_valid_q && !dst_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && status.flush) begin
						stored_q   <= status.stored;
						has_tail_q <= status.has_tail;
						eot_q      <= end_of_text;
						idx_q      <= 2'd0;
						if (status.stored != 3'd0) begin
							state_q <= ST_CONT;
						end else if (status.has_tail) begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_CONT: begin
					if (adv) begin
						idx_q <= idx_q + 2'd1;
						if (cont_end) begin
							state_q <= has_tail_q ? ST_TAIL : ST_IDLE;
						end
					end
				end
				ST_TAIL: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
	import utf8dec_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum {SINK_FREE, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_word_t  src_data = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_word_t dst_data;

	// decoder state as the predictor sees it
	logic [7:0]  seq_lead = '0;
	logic [2:0]  seq_len = '0;
	logic [2:0]  seq_got = '0;
	logic [30:0] seq_acc = '0;
	logic [7:0]  seq_cont [4];

	out_word_t  step_words [$];
	out_word_t  pending_cps [$];
	out_word_t  want;

	int         mismatches = 0;
	int         bytes_sent = 0;
	int         cycle_cnt = 0;
	int         burst_left = 0;
	logic       src_bursty = 1'b0;
	sink_mode_t sink_mode = SINK_FREE;
	int         hold_len = 0;
	int         hold_cnt = 0;
	int         run_left = 0;

	utf8_to_codepoint_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt = cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sink: free, or runs of stall or go of random length; a requested hold overrides them.
	always @(posedge clk) begin
		if (hold_len != 0) begin
			hold_cnt = hold_len;
			hold_len = 0;
		end
		if (hold_cnt != 0) begin
			hold_cnt = hold_cnt - 1;
			dst_stall <= 1'b1;
		end else if (run_left != 0) begin
			run_left = run_left - 1;
		end else begin
			case (sink_mode)
				SINK_FREE: begin
					dst_stall <= 1'b0;
					run_left = 0;
				end
				SINK_LIGHT: begin
					dst_stall <= ($urandom_range(0, 3) == 0);
					run_left = $urandom_range(0, 3);
				end
				default: begin
					dst_stall <= 1'($urandom_range(0, 1));
					run_left = $urandom_range(0, 7);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (pending_cps.size() == 0) begin
				$display("%0t: unexpected word cp=%h used=%0d last=%b done=%b", $time,
					dst_data.code_point, dst_data.bytes_used, dst_data.last_in_run,
					dst_data.text_done);
				mismatches++;
			end else begin
				want = pending_cps.pop_front();
				if (dst_data !== want) begin
					$display("%0t: expected cp=%h used=%0d last=%b done=%b", $time,
						want.code_point, want.bytes_used, want.last_in_run, want.text_done);
					$display("%0t: actual   cp=%h used=%0d last=%b done=%b", $time,
						dst_data.code_point, dst_data.bytes_used, dst_data.last_in_run,
						dst_data.text_done);
					mismatches++;
				end
			end
		end
	end

	function automatic out_word_t cp_word(input logic [30:0] cp, input logic [2:0] used);
		out_word_t w;
		w.code_point  = cp;
		w.bytes_used  = used;
		w.last_in_run = 1'b0;
		w.text_done   = 1'b0;
		return w;
	endfunction

	// Emit the lead byte and every buffered continuation raw, then drop the sequence.
	function automatic void flush_seq();
		int stored;
		int i;
		stored = (seq_got > 0) ? seq_got - 1 : 0;
		if (stored > 4)
			stored = 4;
		step_words.push_back(cp_word({23'd0, seq_lead}, 3'd1));
		for (i = 0; i < stored; i++)
			step_words.push_back(cp_word({23'd0, seq_cont[i]}, 3'd1));
		seq_len = '0;
		seq_got = '0;
		seq_acc = '0;
	endfunction

	function automatic void decode_byte(input in_word_t w);
		logic [7:0] b;
		logic       fresh;
		logic [2:0] len;
		logic [7:0] mask;
		out_word_t  tail;
		int         i;
		b = w.in_byte;
		fresh = 1'b1;
		step_words.delete();
		if (seq_len != 0) begin
			if ((b & CONT_MASK) == CONT_MATCH) begin
				fresh = 1'b0;
				seq_acc = {seq_acc[24:0], b[5:0]};
				if (seq_got + 3'd1 >= seq_len) begin
					step_words.push_back(cp_word(seq_acc, seq_len));
					seq_len = '0;
					seq_got = '0;
					seq_acc = '0;
				end else if (w.end_of_text) begin
					flush_seq();
					step_words.push_back(cp_word({23'd0, b}, 3'd1));
				end else begin
					seq_cont[2'(seq_got - 3'd1)] = b;
					seq_got = seq_got + 3'd1;
				end
			end else begin
				flush_seq();
			end
		end
		if (fresh) begin
			casez (b)
				8'b110?????: begin len = 3'd2; mask = 8'h1F; end
				8'b1110????: begin len = 3'd3; mask = 8'h0F; end
				8'b11110???: begin len = 3'd4; mask = 8'h07; end
				8'b111110??: begin len = 3'd5; mask = 8'h03; end
				8'b1111110?: begin len = 3'd6; mask = 8'h01; end
				default:     begin len = 3'd0; mask = 8'h00; end
			endcase
			if (len != 0 && !w.end_of_text) begin
				seq_lead = b;
				seq_len  = len;
				seq_got  = 3'd1;
				seq_acc  = {23'd0, b & mask};
			end else begin
				step_words.push_back(cp_word({23'd0, b}, 3'd1));
			end
		end
		if (step_words.size() != 0) begin
			tail = step_words.pop_back();
			tail.last_in_run = 1'b1;
			tail.text_done = w.end_of_text;
			step_words.push_back(tail);
			for (i = 0; i < step_words.size(); i++)
				pending_cps.push_back(step_words[i]);
		end
	endfunction

	function automatic logic [7:0] lead_of(input int len);
		logic [7:0] r;
		r = 8'($urandom);
		case (len)
			2:       return {3'b110, r[4:0]};
			3:       return {4'b1110, r[3:0]};
			4:       return {5'b11110, r[2:0]};
			5:       return {6'b111110, r[1:0]};
			default: return {7'b1111110, r[0]};
		endcase
	endfunction

	function automatic logic [7:0] cont_of();
		logic [5:0] r;
		r = 6'($urandom);
		return {2'b10, r};
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eot);
		in_word_t w;
		w.in_byte = b;
		w.end_of_text = eot;
		if (src_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				src_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			burst_left--;
		end
		src_valid <= 1'b1;
		src_data  <= w;
		do @(posedge clk); while (src_stall);
		decode_byte(w);
		bytes_sent++;
	endtask

	task automatic test_passthrough();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);   // stray continuation
		send_byte(8'hBF, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_sequences();
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		// largest legacy six-byte form
		send_byte(8'hFD, 1'b0);
		repeat (5) send_byte(8'hBF, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_broken();
		// four buffered continuations then a plain byte: six words from one byte
		send_byte(8'hFC, 1'b0);
		repeat (4) send_byte(8'h80, 1'b0);
		send_byte(8'h41, 1'b1);
		// a lead byte breaks the open sequence and opens its own
		send_byte(8'hC5, 1'b0);
		send_byte(8'hE1, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_cut_off();
		send_byte(8'hE0, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hDF, 1'b1);   // lead byte on the last byte of the text
	endtask

	task automatic test_backpressure();
		int i;
		src_bursty = 1'b0;
		sink_mode = SINK_LIGHT;
		hold_len = 300;
		for (i = 0; i < 12; i++) begin
			send_byte(lead_of(6), 1'b0);
			repeat (4) send_byte(cont_of(), 1'b0);
			send_byte(8'($urandom_range(0, 127)), i[0]);
		end
	endtask

	task automatic test_random(input int count);
		int   stop_at;
		int   pick;
		int   len;
		int   n_cont;
		int   i;
		logic eot;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0) begin
				src_bursty = 1'($urandom_range(0, 1));
				sink_mode = sink_mode_t'($urandom_range(0, 2));
			end
			pick = $urandom_range(0, 99);
			eot = ($urandom_range(0, 11) == 0);
			len = $urandom_range(1, 6);
			if (pick < 60) begin
				if (len == 1) begin
					send_byte({1'b0, 7'($urandom)}, eot);
				end else begin
					send_byte(lead_of(len), 1'b0);
					for (i = 1; i < len; i++)
						send_byte(cont_of(), eot && (i == len - 1));
				end
			end else if (pick < 85) begin
				// sequence short of continuations, then an arbitrary byte that may break, cut off or complete it
				if (len == 1)
					len = 2;
				n_cont = $urandom_range(0, len - 2);
				send_byte(lead_of(len), 1'b0);
				for (i = 0; i < n_cont; i++)
					send_byte(cont_of(), 1'b0);
				send_byte(8'($urandom), eot);
			end else begin
				send_byte(8'($urandom), eot);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_sequences();
		test_broken();
		test_cut_off();
		test_random(330);
		test_backpressure();
		src_valid <= 1'b0;
		while (pending_cps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
